@@ rtl/core/tib_pkg.sv @@
// Shared constants, types and register codes for the tick imbalance bar sampler.
package tib_pkg;

    // Ring depths and derived widths.
    localparam int SAMPLE_DEPTH = 256;
    localparam int BAR_DEPTH    = 64;
    localparam int SAW   = $clog2(SAMPLE_DEPTH);
    localparam int BAW   = $clog2(BAR_DEPTH);
    localparam int PTR_W = (SAW > BAW) ? SAW : BAW;
    localparam int SCW   = $clog2(SAMPLE_DEPTH + 1);
    localparam int BCW   = $clog2(BAR_DEPTH + 1);
    localparam int NW    = (SCW > BCW) ? SCW : BCW;

    // Arithmetic widths.
    localparam int NUM_W = 52;
    localparam int DVD_W = 68;
    localparam int DVS_W = 32;
    localparam int DCNT_W = $clog2(DVD_W + 1);

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_IMB_WINDOW = 3'd0,
        REG_BAR_WINDOW = 3'd1,
        REG_INIT_TICKS = 3'd2,
        REG_EMA_MODE   = 3'd3,
        REG_TICKS_MIN  = 3'd4,
        REG_TICKS_MAX  = 3'd5
    } t_reg_idx;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

endpackage

@@ rtl/core/tib_div.sv @@
// Restoring divider that retires one quotient bit per cycle.
module tib_div
    import tib_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    logic [DVD_W-1:0]  r_dvd, n_dvd;
    logic [DVS_W-1:0]  r_rem, n_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        rem_sh = {r_rem, r_dvd[DVD_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        if (!diff[DVS_W]) begin
            n_rem = diff[DVS_W-1:0];
            n_dvd = {r_dvd[DVD_W-2:0], 1'b1};
        end else begin
            n_rem = rem_sh[DVS_W-1:0];
            n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
        end
    end

    // Control: run one step for each bit of the dividend.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath; the dividend register collects the quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

@@ rtl/core/tick_imbalance_bar_sampler_top.sv @@
// Top level of the tick imbalance bar sampler: sequencer, rings, shared multiplier and divider.
//
// Usage
//   Input channel: one signed Q16.16 imbalance sample per beat (i_valid,
//   o_stall). Output channel: one beat per sample with the bar number the
//   tick belongs to and a flag that says whether it closed the bar (o_valid,
//   i_stall). Registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data; the user is to write them only while the block is idle,
//   which the block itself does not enforce. Unknown indexes are ignored.
//   The warm-up tick and every close run a normalised EWMA on one shared
//   32x32 multiplier: a divide for the decay, multiply steps for each ring
//   entry, and a divide for normalising, over up to 256 samples or up to
//   64 bar lengths. A close in adaptive mode runs two EWMAs.
//   One sample is in work at a time; o_stall is high until it is finished.
//   The finished result sits in an output register, so the next sample is
//   taken while it waits; a stalled receiver holds the sequencer only at its
//   last step. Reset (synchronous, active low) restores the register
//   defaults and clears all counters; ring contents are not cleared.
module tick_imbalance_bar_sampler_top
    import tib_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_imbalance_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_bar_index,
    output logic        o_bar_closed,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_CHK    = 17'h00002,
        S_CMUL   = 17'h00004,
        S_CCMP   = 17'h00008,
        S_BPUSH  = 17'h00010,
        S_EDEC   = 17'h00020,
        S_EDECW  = 17'h00040,
        S_ERD    = 17'h00080,
        S_EFIRST = 17'h00100,
        S_EM1    = 17'h00200,
        S_EM2    = 17'h00400,
        S_EM3    = 17'h00800,
        S_EM4    = 17'h01000,
        S_EDIV   = 17'h02000,
        S_EDIVW  = 17'h04000,
        S_EPOST  = 17'h08000,
        S_FIN    = 17'h10000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [8:0]  r_imb_win;
    logic [6:0]  r_bar_win;
    logic        r_ema;
    logic [15:0] r_tmin;
    logic [15:0] r_tmax;

    // Block state.
    logic [31:0]      sample_ring [SAMPLE_DEPTH];
    logic [31:0]      bar_ring [BAR_DEPTH];
    logic [SAW-1:0]   r_shead;
    logic [BAW-1:0]   r_bhead;
    logic [SCW-1:0]   r_scnt;
    logic [BCW-1:0]   r_bcnt;
    logic signed [47:0] r_sum;
    logic [31:0]      r_ticks;
    logic [31:0]      r_cur_bar;
    logic signed [31:0] r_level;
    logic [31:0]      r_exp_ticks;
    logic             r_warm;

    // EWMA working registers.
    logic             r_mode_bar;
    logic             r_ret_close;
    logic [NW-1:0]    r_n;
    logic [NW-1:0]    r_i;
    logic [PTR_W-1:0] r_ptr;
    logic [29:0]      r_d;
    logic [30:0]      r_p;
    logic [39:0]      r_w;
    logic signed [NUM_W-1:0] r_num;
    logic [63:0]      r_acc;
    logic [63:0]      r_prod;
    logic [NUM_W-1:0] r_res;
    logic [31:0]      r_srd;
    logic [31:0]      r_brd;

    // Result held for the output register.
    logic [31:0]      r_res_bar;
    logic             r_res_closed;
    logic             r_out_valid;
    logic [31:0]      r_out_bar;
    logic             r_out_closed;

    // Divider and multiplier hookup.
    t_div_req         div_req;
    logic             div_done;
    logic [DVD_W-1:0] div_q;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;

    logic             accept;
    logic             out_free;
    logic [48:0]      sum_ext;
    logic signed [47:0] sum_sat;
    logic [47:0]      sum_mag;
    logic [31:0]      level_mag;
    logic             warm_cond;
    logic [8:0]       win_s;
    logic [6:0]       win_b;
    logic [NW-1:0]    ew_n;
    logic [NW-1:0]    ew_dn;
    logic [PTR_W+1:0] ew_start;
    logic [PTR_W-1:0] ptr_next;
    logic [NUM_W-1:0] num_mag;
    logic signed [NUM_W-1:0] ring_v;
    logic [64:0]      step_r;
    logic signed [NUM_W-1:0] step_num;
    logic [NW-1:0]    i_next;
    logic [31:0]      level_sat;
    logic [NUM_W-1:0] ticks_lo;
    logic [NUM_W-1:0] ticks_hi;
    logic [NUM_W-1:0] ticks_t;

    assign accept   = (r_state == S_IDLE) && i_valid;
    assign out_free = !r_out_valid || !i_stall;

    // Saturating update of the running sum.
    always_comb begin
        sum_ext = {r_sum[47], r_sum} + {{17{i_imbalance_sample[31]}}, i_imbalance_sample};
        if (sum_ext[48] != sum_ext[47]) begin
            sum_sat = sum_ext[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            sum_sat = signed'(sum_ext[47:0]);
        end
    end

    assign sum_mag   = r_sum[47] ? 48'(-r_sum) : 48'(r_sum);
    assign level_mag = r_level[31] ? 32'(-r_level) : 32'(r_level);
    assign warm_cond = {r_ticks, 8'd0} >= {8'd0, r_exp_ticks};

    // Window clamps and EWMA setup for the selected ring.
    always_comb begin
        if (r_imb_win == 9'd0) begin
            win_s = 9'd1;
        end else if (r_imb_win > 9'(SAMPLE_DEPTH)) begin
            win_s = 9'(SAMPLE_DEPTH);
        end else begin
            win_s = r_imb_win;
        end
        if (r_bar_win == 7'd0) begin
            win_b = 7'd1;
        end else if (r_bar_win > 7'(BAR_DEPTH)) begin
            win_b = 7'(BAR_DEPTH);
        end else begin
            win_b = r_bar_win;
        end
        if (r_mode_bar) begin
            ew_n  = (NW'(r_bcnt) < NW'(win_b)) ? NW'(r_bcnt) : NW'(win_b);
            ew_dn = NW'(win_b);
            if ((PTR_W+2)'(r_bhead) >= (PTR_W+2)'(ew_n)) begin
                ew_start = (PTR_W+2)'(r_bhead) - (PTR_W+2)'(ew_n);
            end else begin
                ew_start = (PTR_W+2)'(r_bhead) + (PTR_W+2)'(BAR_DEPTH) - (PTR_W+2)'(ew_n);
            end
        end else begin
            ew_n  = (NW'(r_scnt) < NW'(win_s)) ? NW'(r_scnt) : NW'(win_s);
            ew_dn = ew_n;
            if ((PTR_W+2)'(r_shead) >= (PTR_W+2)'(ew_n)) begin
                ew_start = (PTR_W+2)'(r_shead) - (PTR_W+2)'(ew_n);
            end else begin
                ew_start = (PTR_W+2)'(r_shead) + (PTR_W+2)'(SAMPLE_DEPTH)
                           - (PTR_W+2)'(ew_n);
            end
        end
    end

    // Ring walk pointer wraps at the depth of the ring in use.
    always_comb begin
        if (r_mode_bar) begin
            ptr_next = (r_ptr == PTR_W'(BAR_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
        end else begin
            ptr_next = (r_ptr == PTR_W'(SAMPLE_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
        end
    end

    // Ring entry as a signed value with the fraction of the EWMA.
    assign ring_v = r_mode_bar ? signed'({12'd0, r_brd, 8'd0})
                               : signed'({{(NUM_W-32){r_srd[31]}}, r_srd});

    // One EWMA step: truncate |num|*d toward zero and add the next entry.
    assign num_mag  = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign step_r   = ({1'b0, r_acc} + {21'd0, r_prod[63:20]}) >> 10;
    assign step_num = (r_num[NUM_W-1] ? NUM_W'(-step_r[NUM_W-1:0]) : step_r[NUM_W-1:0])
                      + ring_v;
    assign i_next   = r_i + 1'b1;

    // Saturation of the expected level and clamp of the expected ticks.
    always_comb begin
        if (r_num[NUM_W-1]) begin
            level_sat = (r_res > NUM_W'(33'h080000000)) ? 32'h80000000
                                                         : 32'(-r_res[31:0]);
        end else begin
            level_sat = (r_res > NUM_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : r_res[31:0];
        end
        ticks_lo = NUM_W'({r_tmin, 8'd0});
        ticks_hi = NUM_W'({r_tmax, 8'd0});
        ticks_t  = r_num[NUM_W-1] ? '0 : r_res;
        if (ticks_t < ticks_lo) begin
            ticks_t = ticks_lo;
        end
        if (ticks_t > ticks_hi) begin
            ticks_t = ticks_hi;
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_CMUL: begin
                mul_a = r_exp_ticks;
                mul_b = level_mag;
            end
            S_EM1: begin
                mul_a = {1'b0, r_p};
                mul_b = {2'b0, r_d};
            end
            S_EM2: begin
                mul_a = num_mag[51:20];
                mul_b = {2'b0, r_d};
            end
            S_EM3: begin
                mul_a = {12'd0, num_mag[19:0]};
                mul_b = {2'b0, r_d};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Divider requests: decay factor and final normalisation.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        if (r_state == S_EDEC) begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'({ew_dn - 1'b1, 30'd0});
            div_req.divisor  = DVS_W'(ew_dn) + 1'b1;
        end else if (r_state == S_EDIV) begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'({num_mag, 16'd0});
            div_req.divisor  = DVS_W'(r_w[39:14]);
        end
    end

    tib_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Ring memories with registered reads at the walk pointer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            sample_ring[r_shead] <= i_imbalance_sample;
        end
        r_srd <= sample_ring[r_ptr[SAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_BPUSH) begin
            bar_ring[r_bhead] <= r_ticks;
        end
        r_brd <= bar_ring[r_ptr[BAW-1:0]];
    end

    // Sequencer and block state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_imb_win    <= 9'd16;
            r_bar_win    <= 7'd8;
            r_ema        <= 1'b0;
            r_tmin       <= 16'd1;
            r_tmax       <= 16'hFFFF;
            r_shead      <= '0;
            r_bhead      <= '0;
            r_scnt       <= '0;
            r_bcnt       <= '0;
            r_sum        <= '0;
            r_ticks      <= '0;
            r_cur_bar    <= '0;
            r_level      <= '0;
            r_exp_ticks  <= 32'd100 << 8;
            r_warm       <= 1'b0;
            r_mode_bar   <= 1'b0;
            r_ret_close  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_IMB_WINDOW: r_imb_win <= i_cfg_data[8:0];
                    REG_BAR_WINDOW: r_bar_win <= i_cfg_data[6:0];
                    REG_INIT_TICKS: begin
                        if (!r_warm) begin
                            r_exp_ticks <= {8'd0, i_cfg_data, 8'd0};
                        end
                    end
                    REG_EMA_MODE:   r_ema  <= i_cfg_data[0];
                    REG_TICKS_MIN:  r_tmin <= i_cfg_data;
                    REG_TICKS_MAX:  r_tmax <= i_cfg_data;
                    default: ;
                endcase
            end

            // Output register loads at the last step and drains when the
            // receiver takes the beat.
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_res_bar    <= r_cur_bar;
                        r_res_closed <= 1'b0;
                        r_sum        <= sum_sat;
                        r_shead      <= (r_shead == SAW'(SAMPLE_DEPTH - 1)) ? '0
                                                                           : r_shead + 1'b1;
                        if (r_scnt != SCW'(SAMPLE_DEPTH)) begin
                            r_scnt <= r_scnt + 1'b1;
                        end
                        if (r_ticks != 32'hFFFFFFFF) begin
                            r_ticks <= r_ticks + 1'b1;
                        end
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (!r_warm && warm_cond) begin
                        r_warm      <= 1'b1;
                        r_mode_bar  <= 1'b0;
                        r_ret_close <= 1'b0;
                        r_state     <= S_EDEC;
                    end else if (r_warm) begin
                        r_state <= S_CMUL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_CMUL: r_state <= S_CCMP;
                S_CCMP: begin
                    // Close when |sum| exceeds expected ticks times |level|.
                    if ({8'd0, sum_mag, 8'd0} > r_prod) begin
                        r_ret_close <= 1'b1;
                        r_mode_bar  <= r_ema;
                        r_state     <= r_ema ? S_BPUSH : S_EDEC;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_BPUSH: begin
                    r_bhead <= (r_bhead == BAW'(BAR_DEPTH - 1)) ? '0 : r_bhead + 1'b1;
                    if (r_bcnt != BCW'(BAR_DEPTH)) begin
                        r_bcnt <= r_bcnt + 1'b1;
                    end
                    r_state <= S_EDEC;
                end
                S_EDEC: begin
                    r_n     <= ew_n;
                    r_ptr   <= ew_start[PTR_W-1:0];
                    r_state <= S_EDECW;
                end
                S_EDECW: begin
                    if (div_done) begin
                        r_d     <= div_q[29:0];
                        r_state <= S_ERD;
                    end
                end
                S_ERD: r_state <= S_EFIRST;
                S_EFIRST: begin
                    r_num   <= ring_v;
                    r_w     <= 40'd1 << 30;
                    r_p     <= 31'd1 << 30;
                    r_i     <= NW'(1);
                    r_ptr   <= ptr_next;
                    r_state <= (r_n == NW'(1)) ? S_EDIV : S_EM1;
                end
                S_EM1: r_state <= S_EM2;
                S_EM2: begin
                    r_p     <= r_prod[60:30];
                    r_w     <= r_w + 40'(r_prod[60:30]);
                    r_state <= S_EM3;
                end
                S_EM3: begin
                    r_acc   <= r_prod;
                    r_state <= S_EM4;
                end
                S_EM4: begin
                    r_num   <= step_num;
                    r_i     <= i_next;
                    r_ptr   <= ptr_next;
                    r_state <= (i_next == r_n) ? S_EDIV : S_EM1;
                end
                S_EDIV: r_state <= S_EDIVW;
                S_EDIVW: begin
                    if (div_done) begin
                        r_res   <= div_q[NUM_W-1:0];
                        r_state <= S_EPOST;
                    end
                end
                S_EPOST: begin
                    if (r_mode_bar) begin
                        // Bar lengths done; the level is refreshed next.
                        r_exp_ticks <= ticks_t[31:0];
                        r_mode_bar  <= 1'b0;
                        r_state     <= S_EDEC;
                    end else begin
                        r_level <= signed'(level_sat);
                        if (r_ret_close) begin
                            r_sum        <= '0;
                            r_ticks      <= '0;
                            r_cur_bar    <= r_cur_bar + 1'b1;
                            r_res_closed <= 1'b1;
                            r_state      <= S_FIN;
                        end else begin
                            r_state <= S_CMUL;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_bar    <= r_res_bar;
                        r_out_closed <= r_res_closed;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_bar_index  = r_out_bar;
    assign o_bar_closed = r_out_closed;

    // The divider only reports back while the sequencer waits for it.
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_EDECW || r_state == S_EDIVW))
        else $error("divider finished outside a wait step");

    // A sample beat takes the block out of idle on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("block still idle after taking a sample");

    // A close can only be reported after warm-up.
    a_close_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_closed) |-> r_warm)
        else $error("bar closed before warm-up");

    // Fill counts never pass their ring depths.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scnt <= SCW'(SAMPLE_DEPTH)) && (r_bcnt <= BCW'(BAR_DEPTH)))
        else $error("ring fill count beyond depth");

endmodule
